[rtl/dtoi_pkg.sv]
// Shared types and constants for the decimal token to int32 parser.
package dtoi_pkg;

   localparam int ByteWidth  = 8;
   localparam int ValueWidth = 32;
   localparam int DigitWidth = 4;
   // Magnitude times ten plus a digit, with the magnitude held at or below 2^31
   localparam int WideWidth  = ValueWidth + 3;

   localparam logic [ValueWidth-1:0] PosLimit = 32'h7FFF_FFFF;
   localparam logic [ValueWidth-1:0] NegLimit = 32'h8000_0000;

   // Character codes
   localparam logic [ByteWidth-1:0] ChNul   = 8'd0;
   localparam logic [ByteWidth-1:0] ChTab   = 8'd9;
   localparam logic [ByteWidth-1:0] ChCr    = 8'd13;
   localparam logic [ByteWidth-1:0] ChSpace = 8'd32;
   localparam logic [ByteWidth-1:0] ChPlus  = 8'd43;
   localparam logic [ByteWidth-1:0] ChMinus = 8'd45;
   localparam logic [ByteWidth-1:0] ChZero  = 8'd48;
   localparam logic [ByteWidth-1:0] ChNine  = 8'd57;

   // Running state of the open token
   typedef struct packed {
      logic                  in_token;
      logic                  negative;
      logic [ValueWidth-1:0] magnitude;
      logic                  over_range;
      logic                  bad_char;
   } tok_state_type;

   localparam tok_state_type TokIdle = '{
      in_token:   1'b0,
      negative:   1'b0,
      magnitude:  '0,
      over_range: 1'b0,
      bad_char:   1'b0
   };

   // What one byte produces
   typedef struct packed {
      logic                  emit;
      logic                  bad;
      logic [ValueWidth-1:0] value;
   } step_out_type;

endpackage

[rtl/dtoi_step.sv]
// Per-byte token update: delimiter test, sign, digit accumulate and result.
module dtoi_step
   import dtoi_pkg::*;
(
   input  tok_state_type        cur,
   input  logic [ByteWidth-1:0] text_byte,
   input  logic                 end_of_argument,
   output tok_state_type        nxt,
   output step_out_type         res
);

   logic                  delim;
   logic                  start;
   logic                  is_digit;
   logic [DigitWidth-1:0] digit;
   logic [WideWidth-1:0]  acc;
   tok_state_type         base;
   tok_state_type         upd;

   assign delim = (text_byte == ChNul) || (text_byte == ChSpace) ||
                  ((text_byte >= ChTab) && (text_byte <= ChCr));
   assign start    = !delim && !cur.in_token;
   assign is_digit = (text_byte >= ChZero) && (text_byte <= ChNine);
   assign digit    = DigitWidth'(text_byte - ChZero);

   // Open a fresh token on its first byte
   assign base = start ? tok_state_type'{in_token: 1'b1, negative: 1'b0, magnitude: '0,
                                         over_range: 1'b0, bad_char: 1'b0} : cur;

   // magnitude * 10 + digit as shift-and-add
   assign acc = {base.magnitude, 3'b000} + {2'b00, base.magnitude, 1'b0} +
                WideWidth'(digit);

   always_comb begin
      upd = base;
      if (!delim) begin
         if (start && (text_byte == ChMinus)) begin
            upd.negative = 1'b1;
         end else if (start && (text_byte == ChPlus)) begin
            upd.negative = 1'b0;
         end else if (is_digit) begin
            if (!base.over_range) begin
               if (acc > WideWidth'(NegLimit)) begin
                  upd.over_range = 1'b1;
                  upd.magnitude  = NegLimit;
               end else begin
                  upd.magnitude = acc[ValueWidth-1:0];
               end
            end
         end else begin
            upd.bad_char = 1'b1;
         end
      end
   end

   always_comb begin
      res.emit = upd.in_token && (delim || end_of_argument);
      // Magnitude never passes 2^31, so bit 31 alone marks "above PosLimit"
      res.bad  = upd.bad_char || upd.over_range ||
                 (!upd.negative && (upd.magnitude > PosLimit));
      if (res.bad) begin
         res.value = '0;
      end else if (upd.negative) begin
         res.value = '0 - upd.magnitude;
      end else begin
         res.value = upd.magnitude;
      end
      nxt = res.emit ? TokIdle : upd;
   end

endmodule

[rtl/decimal_token_to_int32_parser.sv]
// Top level: streaming ASCII decimal token to signed 32-bit integer parser.
//
//   Channel | Ports   | tdata (low bit up)       | tuser / tlast
//   --------+---------+--------------------------+------------------------------
//   input   | req_*   | [7:0] text_byte          | tlast = end_of_argument
//   result  | rsp_*   | [31:0] value (signed)    | tuser = bad
//
// One byte is taken per cycle while no closing byte is held; the rate is set by
// the single token-state register that the byte updates, fed from the input
// register. A closing byte's result goes from there to the result register
// on rsp_*. That byte waits in the input register while the result register
// is full and not being taken; no other byte waits there on rsp_tready.
// reset (synchronous, active high) empties both registers and closes any token.
module decimal_token_to_int32_parser
   import dtoi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ByteWidth-1:0]  req_tdata,   // [7:0] text_byte
   input  logic                  req_tlast,   // end_of_argument
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [ValueWidth-1:0] rsp_tdata,   // [31:0] value
   output logic                  rsp_tuser    // [0] bad
);

   // Input register
   logic                  in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0]  in_byte_ff, in_byte_in;
   logic                  in_last_ff, in_last_in;

   // Token state
   tok_state_type         tok_ff, tok_in;

   // Result register
   logic                  out_valid_ff, out_valid_in;
   logic [ValueWidth-1:0] out_value_ff, out_value_in;
   logic                  out_bad_ff, out_bad_in;

   tok_state_type         tok_step;
   step_out_type          step_res;
   logic                  out_free;
   logic                  advance;
   logic                  req_take;

   dtoi_step u_step (
      .cur             (tok_ff),
      .text_byte       (in_byte_ff),
      .end_of_argument (in_last_ff),
      .nxt             (tok_step),
      .res             (step_res)
   );

   // Result slot is free when empty or being drained this cycle
   assign out_free = !out_valid_ff || rsp_tready;
   // Retire the held byte unless its result has nowhere to go
   assign advance  = in_valid_ff && (!step_res.emit || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_last_in   = in_last_ff;
      tok_in       = tok_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_bad_in   = out_bad_ff;

      if (advance) begin
         in_valid_in = 1'b0;
         tok_in      = tok_step;
         if (step_res.emit) begin
            out_valid_in = 1'b1;
            out_value_in = step_res.value;
            out_bad_in   = step_res.bad;
         end
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tok_ff       <= TokIdle;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         tok_ff       <= tok_in;
      end
      // Payload: no reset needed
      in_byte_ff   <= in_byte_in;
      in_last_ff   <= in_last_in;
      out_value_ff <= out_value_in;
      out_bad_ff   <= out_bad_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_bad_ff;

   // A flagged token always reports zero
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("flagged result carries a nonzero value");

   // Saturation holds the magnitude at the negative bound
   a_sat_mag: assert property (@(posedge clock) disable iff (reset)
      tok_ff.over_range |-> tok_ff.magnitude == NegLimit)
      else $error("overflow mark without saturated magnitude");

   // Magnitude never passes the negative bound
   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      tok_ff.magnitude <= NegLimit)
      else $error("magnitude past int32 range");

   // A held byte stays put until it retires
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) &&
                                  $stable(in_last_ff))
      else $error("stalled input byte lost or changed");

   // Closing a token clears the token state
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      advance && step_res.emit |=> !tok_ff.in_token && tok_ff.magnitude == '0)
      else $error("token state not cleared after result");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the decimal token to int32 parser.
module testbench;
   import dtoi_pkg::*;

   localparam int HalfPeriod    = 5;
   localparam int ResetCycles   = 10;
   localparam int IdlePercent   = 26;
   localparam int TotalBytes    = 975;   // directed bytes plus about 950 random ones
   localparam int HoldOffAt     = 350;   // byte count from which long output stalls are requested
   localparam int HoldOffCycles = 300;
   localparam int QuietFrom     = 600;   // byte window with no idling on either side
   localparam int QuietTo       = 760;
   localparam int DrainCycles   = 10;    // wait after draining, for stray results to show
   localparam int WatchdogLimit = 5000;

   // Expected outcome of one closed token
   typedef struct packed {
      logic                  bad;
      logic [ValueWidth-1:0] value;
   } token_result_type;

   // Tracks the open token the same way the block does and queues the value
   // each closed token must produce.
   class token_scoreboard;
      bit                  open;
      bit                  negative;
      bit [ValueWidth-1:0] magnitude;
      bit                  over_range;
      bit                  bad_char;
      token_result_type    expected_tokens[$];
      int                  mismatches;
      int                  tokens;
      int                  bad_tokens;

      function void clear_token();
         open       = 0;
         negative   = 0;
         magnitude  = '0;
         over_range = 0;
         bad_char   = 0;
      endfunction

      function bit is_delimiter(logic [ByteWidth-1:0] b);
         return b == ChNul || b == ChSpace || (b >= ChTab && b <= ChCr);
      endfunction

      // Accumulate a digit, or mark the token bad for anything else
      function void take_byte(logic [ByteWidth-1:0] b);
         bit [ValueWidth+3:0] wide;
         if (b >= ChZero && b <= ChNine) begin
            if (!over_range) begin
               wide = magnitude * 10 + (b - ChZero);
               if (wide > NegLimit) begin
                  over_range = 1;
                  magnitude  = NegLimit;
               end else begin
                  magnitude = wide[ValueWidth-1:0];
               end
            end
         end else begin
            bad_char = 1;
         end
      endfunction

      function void note_byte(logic [ByteWidth-1:0] b, logic last);
         token_result_type r;
         bit               delim;
         delim = is_delimiter(b);
         if (!delim) begin
            if (!open) begin
               clear_token();
               open = 1;
               if (b == ChMinus) negative = 1;
               else if (b != ChPlus) take_byte(b);
            end else begin
               take_byte(b);
            end
         end
         if (open && (delim || last)) begin
            r.bad   = bad_char || over_range || (!negative && magnitude > PosLimit);
            r.value = r.bad ? '0 : (negative ? -magnitude : magnitude);
            expected_tokens.push_back(r);
            tokens++;
            if (r.bad) bad_tokens++;
            clear_token();
         end
      endfunction

      task report_mismatch(string what, logic [ValueWidth-1:0] got,
                           logic [ValueWidth-1:0] want);
         $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_result(logic [ValueWidth-1:0] value, logic bad);
         token_result_type want;
         if (expected_tokens.size() == 0) begin
            report_mismatch("unexpected result value", value, '0);
         end else begin
            want = expected_tokens.pop_front();
            if (value !== want.value) report_mismatch("value", value, want.value);
            if (bad !== want.bad) begin
               report_mismatch("bad flag", ValueWidth'(bad), ValueWidth'(want.bad));
            end
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ByteWidth-1:0]  req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [ValueWidth-1:0] rsp_tdata;
   logic                  rsp_tuser;

   token_scoreboard       sb = new();

   logic [ByteWidth-1:0]  text_q[$];     // bytes of the token being built
   bit                    last_q[$];     // end-of-argument mark per queued byte
   bit                    sender_quiet;
   bit                    receiver_quiet;
   bit                    hold_request;
   int                    hold_left;
   int                    bytes_sent;
   int                    idle_gaps;
   int                    stall_cycles;

   decimal_token_to_int32_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #HalfPeriod clock = ~clock;

   // Sample both channels at the rising edge: feed accepted bytes to the
   // predictor, check accepted results, and count cycles with no progress.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= WatchdogLimit) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     stall_cycles, sb.expected_tokens.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Result side: random back-pressure, a clean stretch, and long hold-offs
   // on request, during which the sender keeps offering bytes.
   initial begin
      rsp_tready = 1'b0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left    = HoldOffCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= receiver_quiet || ($urandom_range(99) >= IdlePercent);
         end
      end
   end

   // Offer one byte, with random gaps first; return at the falling edge after
   // the byte is taken so the next byte can follow with no gap.
   task send_byte(logic [ByteWidth-1:0] b, logic last);
      while (!sender_quiet && $urandom_range(99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         idle_gaps++;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task send_queued();
      foreach (text_q[i]) send_byte(text_q[i], last_q[i]);
      text_q.delete();
      last_q.delete();
   endtask

   task add(logic [ByteWidth-1:0] b, bit last = 0);
      text_q.push_back(b);
      last_q.push_back(last);
   endtask

   task add_text(string s);
      for (int i = 0; i < s.len(); i++) add(s[i]);
   endtask

   function logic [ByteWidth-1:0] pick_delimiter();
      int k;
      k = $urandom_range(6);
      if (k == 6) return ChSpace;
      if (k == 5) return ChNul;
      return ChTab + ByteWidth'(k);
   endfunction

   // Close the token either by end-of-argument on its final byte or by one or
   // two delimiters, the final one sometimes also marked end-of-argument.
   task close_token();
      int n;
      if (text_q.size() != 0 && $urandom_range(99) < 30) begin
         last_q[last_q.size()-1] = 1;
      end else begin
         n = $urandom_range(1, 2);
         repeat (n) add(pick_delimiter());
         if ($urandom_range(99) < 20) last_q[last_q.size()-1] = 1;
      end
   endtask

   // Optional sign, then a decimal string biased toward the int32 edges,
   // small values, leading zeros and far-too-long numbers.
   task add_number();
      longint unsigned v;
      int              s;
      s = $urandom_range(2);
      if (s == 1) add(ChMinus);
      if (s == 2) add(ChPlus);
      case ($urandom_range(4))
         0: v = $urandom();
         1: v = $urandom_range(999);
         2: v = 64'd2147483640 + $urandom_range(15);
         3: v = {$urandom(), $urandom()} >> $urandom_range(30);
         default: begin
            repeat ($urandom_range(1, 3)) add(ChZero);
            v = $urandom_range(99999);
         end
      endcase
      add_text($sformatf("%0d", v));
   endtask

   task add_random_token();
      int                   kind;
      int                   pos;
      logic [ByteWidth-1:0] junk;
      kind = $urandom_range(99);
      if (kind < 60) begin
         add_number();
      end else if (kind < 70) begin
         add($urandom_range(1) ? ChMinus : ChPlus);
      end else if (kind < 85) begin
         // Well-formed number with one stray byte dropped in
         add_number();
         do begin
            junk = ($urandom_range(9) == 0) ? ($urandom_range(1) ? ChMinus : ChPlus)
                                            : 8'($urandom_range(255));
         end while (sb.is_delimiter(junk));
         pos = $urandom_range(text_q.size());
         text_q.insert(pos, junk);
         last_q.insert(pos, 0);
      end else begin
         // Raw noise, delimiters and end marks included
         repeat ($urandom_range(1, 4)) begin
            add(ByteWidth'($urandom_range(255)), $urandom_range(9) == 0);
         end
      end
      close_token();
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      sender_quiet   = 0;
      receiver_quiet = 0;
      hold_request   = 0;
      bytes_sent     = 0;
      idle_gaps      = 0;

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: minimum value, lone signs, second sign, high-bit bytes,
      // a delimiter with end-of-argument between tokens, every delimiter kind
      add_text("-2147483648 ");
      add_text("+\t");
      add(ChMinus, 1);
      add_text("0+");
      add(8'd11);
      add(8'hFF);
      add(8'h80);
      add(ChNul);
      add(8'd12, 1);
      add_text("7\r");
      add_text("9\n");
      send_queued();

      // Random tokens; long output stalls, then a stretch with no idling
      while (bytes_sent < TotalBytes) begin
         if (bytes_sent >= HoldOffAt && bytes_sent < HoldOffAt + 20) hold_request = 1;
         sender_quiet   = bytes_sent >= QuietFrom && bytes_sent < QuietTo;
         receiver_quiet = sender_quiet;
         add_random_token();
         send_queued();
      end
      req_tvalid <= 1'b0;

      // Drain the outstanding results, then give stray results time to show
      while (sb.expected_tokens.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Run covered %0d bytes forming %0d tokens, %0d of them flagged bad.",
               bytes_sent, sb.tokens, sb.bad_tokens);
      $display("Signs, int32 edges and overflow seen with %0d input gaps and %0d-cycle stalls.",
               idle_gaps, HoldOffCycles);
      if (sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
